// File: hdl/calc_pkg.sv
// Package for the channel alarm LED controller.
// Transaction types, op/kind/level codes, sizing constants and controller state type.
// No dependencies.
package calc_pkg;

	localparam int CHANNELS    = 4;
	localparam int REPORTS_MAX = 4;
	localparam int REPORTS     = (CHANNELS < REPORTS_MAX) ? CHANNELS : REPORTS_MAX;
	localparam int RPT_W       = (REPORTS > 1) ? $clog2(REPORTS) : 1;
	localparam int LED_PAD     = (CHANNELS > 4) ? CHANNELS : 4;

	// blink phase after reset: 0,0,1,0 for channels 0..3, 0 beyond
	localparam logic [15:0] PHASE_INIT_PAD = 16'h0004;
	localparam logic [CHANNELS-1:0] PHASE_RST = PHASE_INIT_PAD[CHANNELS-1:0];

	localparam logic [1:0] OP_CMD  = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_HB   = 2'd2;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_HB   = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [1:0] LVL_NONE   = 2'd0;
	localparam logic [1:0] LVL_WARN   = 2'd1;
	localparam logic [1:0] LVL_DANGER = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  channel;
		logic [1:0]  level;
		logic        horn_pin;
		logic        beeper_pin;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  report_channel;
		logic        flag_red;
		logic        flag_yellow;
		logic        flag_green;
		logic        horn_on;
		logic        beeper_on;
		logic [31:0] stamp_ms;
		logic [3:0]  led_drive;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic apply;
		logic load;
		logic idx_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       idx_last;
		logic       slot_free;
	} dp_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctrl_state_t;

endpackage

// File: hdl/calc_datapath.sv
// Datapath: held transaction, per-channel level/phase store, LED register,
// heartbeat index and registered response stage. Depends on calc_pkg.
module calc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  calc_pkg::req_t    req,
	input  calc_pkg::dp_cmd_t cmd,
	output calc_pkg::dp_sts_t sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output calc_pkg::rsp_t    rsp
);
	import calc_pkg::*;

	req_t                item_q;
	logic [1:0]          risk_q  [CHANNELS];
	logic [CHANNELS-1:0] phase_q;
	logic [CHANNELS-1:0] led_q;
	logic [RPT_W-1:0]    idx_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [CHANNELS-1:0] phase_nxt;
	logic [CHANNELS-1:0] led_nxt;
	logic [LED_PAD-1:0]  led_pad;
	logic                in_range;
	logic [1:0]          hb_lvl;
	logic [1:0]          rep_lvl;
	rsp_t                rsp_nxt;

	assign in_range = ({24'd0, item_q.channel} < 32'(CHANNELS));

	always_comb begin
		phase_nxt = phase_q;
		led_nxt   = led_q;
		for (int i = 0; i < CHANNELS; i++) begin
			if (item_q.op == OP_CMD) begin
				if (in_range && (item_q.channel == 8'(i))) begin
					unique case (item_q.level)
						LVL_WARN: begin
							phase_nxt[i] = 1'b1;
							led_nxt[i]   = 1'b1;
						end
						LVL_DANGER: begin
							phase_nxt[i] = 1'b0;
							led_nxt[i]   = 1'b1;
						end
						default: begin
							phase_nxt[i] = 1'b0;
							led_nxt[i]   = 1'b0;
						end
					endcase
				end
			end else begin
				unique case (risk_q[i])
					LVL_WARN: begin
						phase_nxt[i] = ~phase_q[i];
						led_nxt[i]   = ~phase_q[i];
					end
					LVL_DANGER: begin
						phase_nxt[i] = 1'b0;
						led_nxt[i]   = 1'b1;
					end
					default: begin
						phase_nxt[i] = 1'b0;
						led_nxt[i]   = 1'b0;
					end
				endcase
			end
		end
	end

	always_comb begin
		hb_lvl = LVL_NONE;
		for (int i = 0; i < REPORTS; i++) begin
			if (idx_q == RPT_W'(i)) begin
				hb_lvl = risk_q[i];
			end
		end
	end

	always_comb begin
		rsp_nxt = '0;
		rep_lvl = LVL_NONE;
		led_pad = LED_PAD'(led_q);
		unique case (item_q.op)
			OP_CMD: begin
				rep_lvl                = in_range ? item_q.level : LVL_NONE;
				led_pad                = LED_PAD'(led_nxt);
				rsp_nxt.kind           = KIND_ACK;
				rsp_nxt.report_channel = item_q.channel;
				rsp_nxt.last           = 1'b1;
			end
			OP_TICK: begin
				led_pad      = LED_PAD'(led_nxt);
				rsp_nxt.kind = KIND_TICK;
				rsp_nxt.last = 1'b1;
			end
			default: begin
				rep_lvl                = hb_lvl;
				rsp_nxt.kind           = KIND_HB;
				rsp_nxt.report_channel = 8'(idx_q);
				rsp_nxt.last           = (idx_q == RPT_W'(REPORTS - 1));
			end
		endcase
		if (item_q.op != OP_TICK) begin
			rsp_nxt.flag_red    = (rep_lvl == LVL_DANGER);
			rsp_nxt.flag_yellow = (rep_lvl == LVL_WARN);
			rsp_nxt.flag_green  = (rep_lvl == LVL_NONE);
			rsp_nxt.horn_on     = item_q.horn_pin;
			rsp_nxt.beeper_on   = item_q.beeper_pin;
			rsp_nxt.stamp_ms    = item_q.now_ms;
		end
		rsp_nxt.led_drive = led_pad[3:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.load) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				risk_q[i] <= LVL_NONE;
			end
			phase_q     <= PHASE_RST;
			led_q       <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				phase_q <= phase_nxt;
				led_q   <= led_nxt;
				for (int i = 0; i < CHANNELS; i++) begin
					if ((item_q.op == OP_CMD) && in_range && (item_q.channel == 8'(i))) begin
						risk_q[i] <= item_q.level;
					end
				end
			end
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + RPT_W'(1);
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op        = item_q.op;
	assign sts.idx_last  = (idx_q == RPT_W'(REPORTS - 1));
	assign sts.slot_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

// File: hdl/calc_ctrl.sv
// Controller state machine: takes a transaction, then sequences update and
// response loads. Depends on calc_pkg.
module calc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  calc_pkg::dp_sts_t sts,
	output calc_pkg::dp_cmd_t cmd
);
	import calc_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				priority if (sts.op == OP_CMD || sts.op == OP_TICK) begin
					if (sts.slot_free) begin
						cmd.apply = 1'b1;
						cmd.load  = 1'b1;
						state_nxt = ST_IDLE;
					end
				end else if (sts.op == OP_HB) begin
					if (sts.slot_free) begin
						cmd.load = 1'b1;
						if (sts.idx_last) begin
							state_nxt = ST_IDLE;
						end else begin
							cmd.idx_inc = 1'b1;
						end
					end
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/channel_alarm_led_controller.sv
// Channel alarm LED controller, top level: joins calc_ctrl and calc_datapath.
// Depends on calc_pkg, calc_ctrl, calc_datapath.
//
// Request channel (req_valid/req_ready, req): op selects command, LED refresh
// tick or heartbeat request. Response channel (rsp_valid/rsp_ready, rsp):
// acknowledge, refresh or heartbeat reports, last set on the final one.
// One transaction is worked on at a time by the controller FSM.
// Sequencing: the response is registered; a command or tick is captured in
// the idle state, and its single response is loaded in the execute state
// once the response register is free, then the FSM returns to idle to take
// a new request. A heartbeat loads one report per cycle, while the response
// register is free, from the held transaction and level store; four reports.
// Op 3 is dropped with no response.
// Reset: level store cleared to none, blink phases 0,0,1,0, LEDs off, no
// response pending. When the receiver stalls, the response register holds;
// the FSM still takes one more request, then waits before updating state or
// loading the next report, holding req_ready low until the register empties.
module channel_alarm_led_controller (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  calc_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output calc_pkg::rsp_t rsp
);
	import calc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	calc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	calc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
